/* hdl/ibm_pkg.sv */
// ----------------------------------------------------------------------------
// ibm_pkg: shared types and constants of the I2C byte master
// Item and result structures, request codes, status codes and defaults.
// ----------------------------------------------------------------------------
package ibm_pkg;

   localparam int unsigned PHASE_W = 16;
   localparam int unsigned RECOVERY_PULSES_DEF = 9;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_STOP  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_STUCK    = 2'd1;
   localparam logic [1:0] STAT_NO_START = 2'd2;

   localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd1;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       ready_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_received;
      logic [1:0] status;
   } result_type;

endpackage

/* hdl/ibm_seq.sv */
// ----------------------------------------------------------------------------
// ibm_seq: bus phase sequencer
// Holds the phase state and line drive; advances one tick per step.
// ----------------------------------------------------------------------------
module ibm_seq #(
   parameter int unsigned RECOVERY_PULSES = ibm_pkg::RECOVERY_PULSES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  ibm_pkg::item_type             item,
   input  logic [ibm_pkg::PHASE_W-1:0]   phase_ticks,
   output ibm_pkg::result_type           result
);

   localparam logic [4:0] P_IDLE     = 5'd0;
   localparam logic [4:0] P_ST_REL   = 5'd1;
   localparam logic [4:0] P_RC_HIGH  = 5'd2;
   localparam logic [4:0] P_RC_LOW   = 5'd3;
   localparam logic [4:0] P_RC_CHECK = 5'd4;
   localparam logic [4:0] P_ST_LOW   = 5'd5;
   localparam logic [4:0] P_ST_HOLD  = 5'd6;
   localparam logic [4:0] P_SP_A     = 5'd7;
   localparam logic [4:0] P_SP_B     = 5'd8;
   localparam logic [4:0] P_SP_C     = 5'd9;
   localparam logic [4:0] P_SP_D     = 5'd10;
   localparam logic [4:0] P_WR_LOW   = 5'd11;
   localparam logic [4:0] P_WR_DATA  = 5'd12;
   localparam logic [4:0] P_WR_HIGH  = 5'd13;
   localparam logic [4:0] P_WA_LOW   = 5'd14;
   localparam logic [4:0] P_WA_REL   = 5'd15;
   localparam logic [4:0] P_WA_HIGH  = 5'd16;
   localparam logic [4:0] P_RD_LOW   = 5'd17;
   localparam logic [4:0] P_RD_HIGH  = 5'd18;
   localparam logic [4:0] P_RA_LOW   = 5'd19;
   localparam logic [4:0] P_RA_DATA  = 5'd20;
   localparam logic [4:0] P_RA_HIGH  = 5'd21;
   localparam logic [4:0] P_RA_END   = 5'd22;

   localparam logic [3:0] PULSES_M1 = 4'((RECOVERY_PULSES - 1) % 16);
   localparam logic [3:0] BITS_M1   = 4'd7;

   logic [4:0]                  state_ff, state_in;
   logic [3:0]                  bit_ff, bit_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [ibm_pkg::PHASE_W-1:0] tick_ff, tick_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in;
   logic                        ackp_ff, ackp_in;
   logic [7:0]                  rx_ff, rx_in;
   logic                        ackh_ff, ackh_in;
   logic [1:0]                  stat_ff, stat_in;
   logic                        done;
   logic                        go;
   logic [4:0]                  go_p;
   logic                        phase_end;
   logic [ibm_pkg::PHASE_W:0]   tick_sum;

   assign tick_sum  = {1'b0, tick_ff} + {{ibm_pkg::PHASE_W{1'b0}}, 1'b1};
   assign phase_end = tick_sum >= {1'b0, phase_ticks};

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ackp_in  = ackp_ff;
      rx_in    = rx_ff;
      ackh_in  = ackh_ff;
      stat_in  = stat_ff;
      done     = 1'b0;
      go       = 1'b0;
      go_p     = P_IDLE;

      if (state_ff == P_IDLE) begin
         if (item.cmd_valid) begin
            stat_in = ibm_pkg::STAT_OK;
            go      = 1'b1;
            unique case (item.req_type)
               ibm_pkg::REQ_START: go_p = P_ST_REL;
               ibm_pkg::REQ_STOP:  go_p = P_SP_A;
               ibm_pkg::REQ_WRITE: begin
                  shift_in = item.tx_byte;
                  bit_in   = BITS_M1;
                  go_p     = P_WR_LOW;
               end
               default: begin
                  shift_in = 8'd0;
                  bit_in   = BITS_M1;
                  ackp_in  = item.send_ack;
                  sda_in   = 1'b1;
                  go_p     = P_RD_LOW;
               end
            endcase
         end
      end else if (phase_end) begin
         go = 1'b1;
         unique case (state_ff)
            P_ST_REL: begin
               if (!item.sda_in) begin
                  bit_in = PULSES_M1;
                  go_p   = P_RC_HIGH;
               end else begin
                  go_p = P_ST_LOW;
               end
            end
            P_RC_HIGH: go_p = P_RC_LOW;
            P_RC_LOW: begin
               if (bit_ff == 4'd0) begin
                  go_p = P_RC_CHECK;
               end else begin
                  bit_in = bit_ff - 4'd1;
                  go_p   = P_RC_HIGH;
               end
            end
            P_RC_CHECK: begin
               if (!item.sda_in) begin
                  stat_in = ibm_pkg::STAT_STUCK;
                  go      = 1'b0;
                  done    = 1'b1;
               end else begin
                  go_p = P_ST_LOW;
               end
            end
            P_ST_LOW: begin
               if (item.sda_in) begin
                  stat_in = ibm_pkg::STAT_NO_START;
                  go      = 1'b0;
                  done    = 1'b1;
               end else begin
                  go_p = P_ST_HOLD;
               end
            end
            P_SP_A:    go_p = P_SP_B;
            P_SP_B:    go_p = P_SP_C;
            P_SP_C:    go_p = P_SP_D;
            P_WR_LOW:  go_p = P_WR_DATA;
            P_WR_DATA: go_p = P_WR_HIGH;
            P_WR_HIGH: begin
               if (bit_ff == 4'd0) begin
                  go_p = P_WA_LOW;
               end else begin
                  bit_in = bit_ff - 4'd1;
                  go_p   = P_WR_LOW;
               end
            end
            P_WA_LOW: go_p = P_WA_REL;
            P_WA_REL: go_p = P_WA_HIGH;
            P_WA_HIGH: begin
               ackh_in = ~item.sda_in;
               scl_in  = 1'b0;
               go      = 1'b0;
               done    = 1'b1;
            end
            P_RD_LOW: go_p = P_RD_HIGH;
            P_RD_HIGH: begin
               shift_in = {shift_ff[6:0], item.sda_in};
               if (bit_ff == 4'd0) begin
                  rx_in = {shift_ff[6:0], item.sda_in};
                  go_p  = P_RA_LOW;
               end else begin
                  bit_in = bit_ff - 4'd1;
                  go_p   = P_RD_LOW;
               end
            end
            P_RA_LOW:  go_p = P_RA_DATA;
            P_RA_DATA: go_p = P_RA_HIGH;
            P_RA_HIGH: go_p = P_RA_END;
            default: begin
               go   = 1'b0;
               done = 1'b1;
            end
         endcase
         if (done) begin
            state_in = P_IDLE;
            tick_in  = '0;
         end
      end else begin
         tick_in = tick_sum[ibm_pkg::PHASE_W-1:0];
      end

      // apply the entry actions of the next phase
      if (go) begin
         state_in = go_p;
         tick_in  = '0;
         unique case (go_p)
            P_ST_REL: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
            end
            P_RC_HIGH, P_RC_CHECK, P_SP_C, P_WR_HIGH, P_WA_HIGH, P_RD_HIGH,
            P_RA_HIGH:
               scl_in = 1'b1;
            P_RC_LOW, P_SP_A, P_WR_LOW, P_WA_LOW, P_RD_LOW, P_RA_LOW, P_RA_END:
               scl_in = 1'b0;
            P_ST_LOW, P_ST_HOLD, P_SP_B:
               sda_in = 1'b0;
            P_SP_D, P_WA_REL:
               sda_in = 1'b1;
            P_WR_DATA: begin
               sda_in   = shift_in[7];
               shift_in = {shift_in[6:0], 1'b0};
            end
            P_RA_DATA:
               sda_in = ~ackp_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         bit_ff   <= '0;
         shift_ff <= '0;
         tick_ff  <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ackp_ff  <= 1'b0;
         rx_ff    <= '0;
         ackh_ff  <= 1'b0;
         stat_ff  <= ibm_pkg::STAT_OK;
      end else if (step) begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         tick_ff  <= tick_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ackp_ff  <= ackp_in;
         rx_ff    <= rx_in;
         ackh_ff  <= ackh_in;
         stat_ff  <= stat_in;
      end
   end

   always_comb begin
      result.scl_out      = scl_in;
      result.sda_out      = sda_in;
      result.ready_res    = (state_in == P_IDLE);
      result.done_res     = done;
      result.rx_byte      = rx_in;
      result.ack_received = ackh_in;
      result.status       = stat_in;
   end

endmodule

/* hdl/i2c_byte_master.sv */
// ----------------------------------------------------------------------------
// i2c_byte_master: byte-level I2C master with open-drain line drive
// Each request transaction is one bus tick carrying sampled SDA and an
// optional command (start, stop, write byte, read byte). Each tick yields one
// response transaction with the SCL/SDA drive, ready, done and the results.
// Usage:
//  - req_ channel: valid/ready; one tick per accepted transaction.
//  - rsp_ channel: valid/ready; one response per request, in order.
//  - csr_wr_en/csr_wr_data write phase_ticks (ticks per bus phase); write
//    only while no transaction is in flight. Zero behaves as one.
//  - Path: from request acceptance to response valid via the input
//    register, then sequencer update into the response register.
//  - Throughput: one transaction per cycle while rsp_ready holds; the
//    sequencer advances once per tick with a single pass of next-state logic.
//  - Reset: sequencer idle, both lines released, phase_ticks = 1, results 0.
//  - A stalled rsp_ready holds the response register; the input register
//    then fills and req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module i2c_byte_master #(
   parameter int unsigned RECOVERY_PULSES = ibm_pkg::RECOVERY_PULSES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd_valid,
   input  logic [1:0]                  req_type,
   input  logic [7:0]                  req_tx_byte,
   input  logic                        req_send_ack,
   input  logic                        req_sda_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_scl_out,
   output logic                        rsp_sda_out,
   output logic                        rsp_ready_res,
   output logic                        rsp_done_res,
   output logic [7:0]                  rsp_rx_byte,
   output logic                        rsp_ack_received,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_wr_en,
   input  logic [ibm_pkg::PHASE_W-1:0] csr_wr_data
);

   logic                        in_valid_ff;
   ibm_pkg::item_type           in_item_ff;
   logic                        out_valid_ff;
   ibm_pkg::result_type         out_res_ff;
   logic [ibm_pkg::PHASE_W-1:0] phase_ticks_ff;
   ibm_pkg::result_type         seq_res;
   logic                        step;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= ibm_pkg::PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.cmd_valid <= req_cmd_valid;
         in_item_ff.req_type  <= req_type;
         in_item_ff.tx_byte   <= req_tx_byte;
         in_item_ff.send_ack  <= req_send_ack;
         in_item_ff.sda_in    <= req_sda_in;
      end
   end

   ibm_seq #(
      .RECOVERY_PULSES (RECOVERY_PULSES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (in_item_ff),
      .phase_ticks (phase_ticks_ff),
      .result      (seq_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_res_ff <= seq_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_out      = out_res_ff.scl_out;
   assign rsp_sda_out      = out_res_ff.sda_out;
   assign rsp_ready_res    = out_res_ff.ready_res;
   assign rsp_done_res     = out_res_ff.done_res;
   assign rsp_rx_byte      = out_res_ff.rx_byte;
   assign rsp_ack_received = out_res_ff.ack_received;
   assign rsp_status       = out_res_ff.status;

`ifndef SYNTHESIS
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.done_res |-> out_res_ff.ready_res)
      else $error("done without return to idle");

   a_step_fills : assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("sequencer step did not produce a response");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request stalled without a full pipeline");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status != ibm_pkg::STAT_OK |->
      out_res_ff.ready_res)
      else $error("failure status while a command is running");
`endif

endmodule
